/* rtl/prmf_pkg.sv */
package prmf_pkg;

    // Command codes carried in the input item's tuser field.
    typedef enum logic [1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_SOLVE = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_NODE_COUNT  = 2'd0;
    localparam logic [1:0] CFG_SOURCE_NODE = 2'd1;
    localparam logic [1:0] CFG_SINK_NODE   = 2'd2;

    localparam int FLOW_BITS = 21;

    typedef struct packed {
        func_t       func;
        logic [15:0] arc_capacity;
        logic [4:0]  arc_head;
        logic [4:0]  arc_tail;
    } cmd_t;

    typedef struct packed {
        logic [5:0] node_count;
        logic [4:0] source_node;
        logic [4:0] sink_node;
    } cfg_t;

    typedef struct packed {
        logic                 last;
        logic [FLOW_BITS-1:0] max_flow;
        logic                 source_side;
        logic [4:0]           node_id;
    } res_t;

endpackage

/* rtl/push_relabel_max_flow.sv */
// Highest-label push-relabel maximum flow. Arcs are loaded one item at a time
// into a dense NODES x NODES residual-capacity memory; a later arc with the same
// ends replaces the earlier one and self loops are dropped. A clear item, and
// reset itself, sweeps the capacity memory one entry per cycle, during which
// no item is taken; configuration writes are taken at any time. A solve item
// first rewrites the node memory, saturates the source arcs, then repeatedly
// pops the highest-label active node and scans its matrix row, examining each
// neighbor, pushing where it can and queueing any node that it activates. Solve
// time depends on the graph and is set by the single read port of the
// capacity and node memories. The solve ends with one result item per node in
// use, each carrying the node's min-cut side and the flow gathered at the
// sink, with tlast on the final node. The solve works in place, so a repeated
// solve without reloading reports only the additional flow it finds.
module push_relabel_max_flow #(
    parameter int NODES    = 32,
    parameter int CAP_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // arc_tail[4:0], arc_head[9:5], arc_capacity[25:10]
    input  logic [1:0]  s_tuser,   // func[1:0]
    // Result items.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // node_id[4:0], source_side[5], max_flow[26:6]
    output logic        m_tlast,
    // Configuration writes.
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [5:0]  cfg_wdata
);
    import prmf_pkg::*;

    cfg_t cfg_reg;
    cmd_t cmd;
    res_t eng_res;
    res_t m_res_reg;
    logic m_tvalid_reg;
    logic eng_res_valid;
    logic eng_res_ready;

    // Configuration registers; an index beyond the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.node_count  <= 6'd32;
            cfg_reg.source_node <= 5'd0;
            cfg_reg.sink_node   <= 5'd31;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_NODE_COUNT:  cfg_reg.node_count  <= cfg_wdata;
                CFG_SOURCE_NODE: cfg_reg.source_node <= cfg_wdata[4:0];
                CFG_SINK_NODE:   cfg_reg.sink_node   <= cfg_wdata[4:0];
                default: begin
                end
            endcase
        end
    end

    // Unpack the input item.
    assign cmd.func         = func_t'(s_tuser);
    assign cmd.arc_tail     = s_tdata[4:0];
    assign cmd.arc_head     = s_tdata[9:5];
    assign cmd.arc_capacity = s_tdata[25:10];

    prmf_engine #(
        .NODES    (NODES),
        .CAP_BITS (CAP_BITS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (s_tvalid),
        .cmd       (cmd),
        .cmd_ready (s_tready),
        .cfg       (cfg_reg),
        .res_valid (eng_res_valid),
        .res       (eng_res),
        .res_ready (eng_res_ready)
    );

    // Output register: it takes a new result whenever it is empty or drained.
    assign eng_res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (eng_res_ready) begin
            m_tvalid_reg <= eng_res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (eng_res_ready && eng_res_valid) begin
            m_res_reg <= eng_res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b00000, m_res_reg.max_flow, m_res_reg.source_side,
                       m_res_reg.node_id};
    assign m_tlast  = m_res_reg.last;

endmodule

/* rtl/prmf_engine.sv */
module prmf_engine #(
    parameter int NODES    = 32,
    parameter int CAP_BITS = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cmd_valid,
    input  prmf_pkg::cmd_t  cmd,
    output logic            cmd_ready,
    input  prmf_pkg::cfg_t  cfg,
    output logic            res_valid,
    output prmf_pkg::res_t  res,
    input  logic            res_ready
);
    import prmf_pkg::*;

    localparam int NW  = $clog2(NODES);
    localparam int NCW = $clog2(NODES + 1);
    localparam int AW  = $clog2(NODES * NODES);
    localparam int RW  = CAP_BITS + 1;
    localparam int EW  = CAP_BITS + 2 + NW;
    localparam int NB  = 2 * NODES + 3;
    localparam int LW  = $clog2(NB);

    typedef struct packed {
        logic [NW-1:0] nxt;
        logic [LW-1:0] label;
        logic [EW-1:0] excess;
    } node_t;

    typedef struct packed {
        logic [NW-1:0] head;
        logic [NW-1:0] tail;
    } bkt_t;

    typedef enum logic [4:0] {
        ST_CLR, ST_IDLE, ST_INIT,
        ST_PK0, ST_PK1, ST_PK2,
        ST_SC0, ST_SC1, ST_SC2, ST_SC3, ST_END,
        ST_BA0, ST_BA1, ST_BA2,
        ST_EM0, ST_EM1, ST_EM2, ST_EM3
    } state_t;

    function automatic logic [NW-1:0] node_mod(input logic [4:0] x);
        logic [6:0] r;
        r = {2'b00, x};
        for (int q = 0; q < 8; q++) begin
            if (r >= 7'(NODES)) r = r - 7'(NODES);
        end
        return NW'(r);
    endfunction

    function automatic logic [NW-1:0] node_of(input logic [4:0] x);
        logic [NW+4:0] w;
        w = {{NW{1'b0}}, x};
        return w[NW-1:0];
    endfunction

    function automatic logic [AW-1:0] cap_addr(input logic [NW-1:0] r,
                                               input logic [NW-1:0] c);
        return AW'(r * NODES) + AW'(c);
    endfunction

    // Memories.
    logic [RW-1:0] cap_mem [NODES*NODES];
    node_t         nd_mem  [NODES];
    bkt_t          bk_mem  [NB];

    logic          cap_we, nd_we, bk_we;
    logic [AW-1:0] cap_waddr, cap_raddr;
    logic [RW-1:0] cap_wdata, cap_rdata;
    logic [NW-1:0] nd_waddr, nd_raddr;
    node_t         nd_wdata, nd_rdata;
    logic [LW-1:0] bk_waddr, bk_raddr;
    bkt_t          bk_wdata, bk_rdata;

    always_ff @(posedge aclk) begin
        if (cap_we) cap_mem[cap_waddr] <= cap_wdata;
        cap_rdata <= cap_mem[cap_raddr];
    end

    always_ff @(posedge aclk) begin
        if (nd_we) nd_mem[nd_waddr] <= nd_wdata;
        nd_rdata <= nd_mem[nd_raddr];
    end

    always_ff @(posedge aclk) begin
        if (bk_we) bk_mem[bk_waddr] <= bk_wdata;
        bk_rdata <= bk_mem[bk_raddr];
    end

    // Control registers.
    state_t          state_reg, state_next;
    logic [AW:0]     ptr_reg, ptr_next;
    logic [NB-1:0]   nonempty_reg, nonempty_next;
    logic [LW-1:0]   highest_reg, highest_next;
    logic            sat_reg, sat_next;
    logic            pushed_reg, pushed_next;
    logic            least_ok_reg, least_ok_next;
    logic            ba_ret_reg, ba_ret_next;
    logic            ok_reg, ok_next;
    logic            t_ok_reg, t_ok_next;
    logic [NCW-1:0]  j_reg, j_next;
    logic [NCW-1:0]  n_reg, n_next;

    // Payload registers.
    logic [NW-1:0]   i_reg, i_next;
    logic [EW-1:0]   cur_ex_reg, cur_ex_next;
    logic [LW-1:0]   cur_lbl_reg, cur_lbl_next;
    logic [NW-1:0]   cur_nxt_reg, cur_nxt_next;
    logic [LW-1:0]   least_reg, least_next;
    logic [RW-1:0]   eps_reg, eps_next;
    node_t           nj_reg, nj_next;
    logic [LW-1:0]   pick_b_reg, pick_b_next;
    logic [NW-1:0]   pick_tail_reg, pick_tail_next;
    logic            pick_last_reg, pick_last_next;
    logic [LW-1:0]   ba_b_reg, ba_b_next;
    logic [NW-1:0]   ba_v_reg, ba_v_next;
    logic [NW-1:0]   ba_tail_reg, ba_tail_next;
    logic [NW-1:0]   s_reg, s_next;
    logic [NW-1:0]   t_reg, t_next;
    logic [FLOW_BITS-1:0] flow_reg, flow_next;

    // Helpers for the scan step.
    logic [NW-1:0]   j_idx;
    logic [LW:0]     lbl_inc;
    logic            admissible;
    logic [RW-1:0]   eps_c;
    logic [LW:0]     least_inc;
    logic [LW-1:0]   new_lbl;
    logic [NCW-1:0]  n_clamp;
    logic [6:0]      s_wide, t_wide, n_wide;
    logic [EW+FLOW_BITS-1:0] flow_wide;
    logic [NCW+4:0]  k_wide;

    assign j_idx      = j_reg[NW-1:0];
    assign lbl_inc    = {1'b0, nd_rdata.label} + 1'b1;
    assign admissible = sat_reg || ({1'b0, cur_lbl_reg} == lbl_inc);
    assign eps_c      = sat_reg ? cap_rdata
                      : ((cur_ex_reg < EW'(cap_rdata)) ? RW'(cur_ex_reg) : cap_rdata);
    assign least_inc  = {1'b0, least_reg} + 1'b1;
    assign new_lbl    = (least_inc > (LW+1)'(NB - 1)) ? LW'(NB - 1) : least_inc[LW-1:0];

    always_comb begin
        if (cfg.node_count < 6'd2)                n_clamp = NCW'(2);
        else if (7'(cfg.node_count) > 7'(NODES))  n_clamp = NCW'(NODES);
        else                                      n_clamp = NCW'(cfg.node_count);
    end

    assign n_wide    = 7'(n_clamp);
    assign s_wide    = 7'(cfg.source_node);
    assign t_wide    = 7'(cfg.sink_node);
    assign flow_wide = {{FLOW_BITS{1'b0}}, nd_rdata.excess};
    assign k_wide    = {5'b00000, j_reg};

    always_comb begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        nonempty_next  = nonempty_reg;
        highest_next   = highest_reg;
        sat_next       = sat_reg;
        pushed_next    = pushed_reg;
        least_ok_next  = least_ok_reg;
        ba_ret_next    = ba_ret_reg;
        ok_next        = ok_reg;
        t_ok_next      = t_ok_reg;
        j_next         = j_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        cur_ex_next    = cur_ex_reg;
        cur_lbl_next   = cur_lbl_reg;
        cur_nxt_next   = cur_nxt_reg;
        least_next     = least_reg;
        eps_next       = eps_reg;
        nj_next        = nj_reg;
        pick_b_next    = pick_b_reg;
        pick_tail_next = pick_tail_reg;
        pick_last_next = pick_last_reg;
        ba_b_next      = ba_b_reg;
        ba_v_next      = ba_v_reg;
        ba_tail_next   = ba_tail_reg;
        s_next         = s_reg;
        t_next         = t_reg;
        flow_next      = flow_reg;

        cap_we = 1'b0; cap_waddr = '0; cap_wdata = '0; cap_raddr = '0;
        nd_we  = 1'b0; nd_waddr  = '0; nd_wdata  = '0; nd_raddr  = '0;
        bk_we  = 1'b0; bk_waddr  = '0; bk_wdata  = '0; bk_raddr  = '0;
        cmd_ready = 1'b0;
        res_valid = 1'b0;
        res       = '0;

        case (state_reg)
            ST_CLR: begin
                // Sweep the whole capacity matrix to zero.
                cap_we    = 1'b1;
                cap_waddr = ptr_reg[AW-1:0];
                if (ptr_reg == (AW+1)'(NODES * NODES - 1)) begin
                    state_next = ST_IDLE;
                end
                ptr_next = ptr_reg + 1'b1;
            end

            ST_IDLE: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    case (cmd.func)
                        FUNC_LOAD: begin
                            if (node_mod(cmd.arc_tail) != node_mod(cmd.arc_head)) begin
                                cap_we    = 1'b1;
                                cap_waddr = cap_addr(node_mod(cmd.arc_tail),
                                                     node_mod(cmd.arc_head));
                                cap_wdata = RW'(cmd.arc_capacity
                                                & 16'((64'd1 << CAP_BITS) - 64'd1));
                            end
                        end
                        FUNC_SOLVE: begin
                            n_next        = n_clamp;
                            ok_next       = (s_wide < n_wide) && (t_wide < n_wide);
                            t_ok_next     = t_wide < n_wide;
                            s_next        = node_of(cfg.source_node);
                            t_next        = node_of(cfg.sink_node);
                            nonempty_next = '0;
                            highest_next  = '0;
                            ptr_next      = '0;
                            state_next    = ST_INIT;
                        end
                        FUNC_CLEAR: begin
                            ptr_next   = '0;
                            state_next = ST_CLR;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_INIT: begin
                // Fresh labels and excesses; the source starts at label n.
                nd_we    = 1'b1;
                nd_waddr = ptr_reg[NW-1:0];
                nd_wdata = '0;
                if (ok_reg && (ptr_reg[NW-1:0] == s_reg)) begin
                    nd_wdata.label = LW'(n_reg);
                end
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == (AW+1)'(NODES - 1)) begin
                    if (!ok_reg || (s_reg == t_reg)) begin
                        state_next = ST_EM0;
                    end else begin
                        sat_next   = 1'b1;
                        i_next     = s_reg;
                        j_next     = '0;
                        state_next = ST_SC0;
                    end
                end
            end

            ST_PK0: begin
                if ((highest_reg != '0) && !nonempty_reg[highest_reg]) begin
                    highest_next = highest_reg - 1'b1;
                end else if (!nonempty_reg[highest_reg]) begin
                    state_next = ST_EM0;
                end else begin
                    bk_raddr    = highest_reg;
                    pick_b_next = highest_reg;
                    state_next  = ST_PK1;
                end
            end

            ST_PK1: begin
                nd_raddr       = bk_rdata.head;
                i_next         = bk_rdata.head;
                pick_tail_next = bk_rdata.tail;
                pick_last_next = bk_rdata.head == bk_rdata.tail;
                state_next     = ST_PK2;
            end

            ST_PK2: begin
                cur_ex_next  = nd_rdata.excess;
                cur_lbl_next = nd_rdata.label;
                cur_nxt_next = nd_rdata.nxt;
                if (pick_last_reg) begin
                    nonempty_next[pick_b_reg] = 1'b0;
                end else begin
                    bk_we    = 1'b1;
                    bk_waddr = pick_b_reg;
                    bk_wdata = '{head: nd_rdata.nxt, tail: pick_tail_reg};
                end
                j_next        = '0;
                pushed_next   = 1'b0;
                least_ok_next = 1'b0;
                state_next    = ST_SC0;
            end

            ST_SC0: begin
                if (j_reg == n_reg) begin
                    state_next = ST_END;
                end else if (j_idx == i_reg) begin
                    j_next = j_reg + 1'b1;
                end else begin
                    cap_raddr  = cap_addr(i_reg, j_idx);
                    nd_raddr   = j_idx;
                    state_next = ST_SC1;
                end
            end

            ST_SC1: begin
                if ((cap_rdata != '0) &&
                    (!least_ok_reg || (nd_rdata.label < least_reg))) begin
                    least_ok_next = 1'b1;
                    least_next    = nd_rdata.label;
                end
                if ((cap_rdata != '0) && admissible) begin
                    cap_we     = 1'b1;
                    cap_waddr  = cap_addr(i_reg, j_idx);
                    cap_wdata  = cap_rdata - eps_c;
                    cap_raddr  = cap_addr(j_idx, i_reg);
                    eps_next   = eps_c;
                    nj_next    = nd_rdata;
                    state_next = ST_SC2;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_SC0;
                end
            end

            ST_SC2: begin
                cap_we    = 1'b1;
                cap_waddr = cap_addr(j_idx, i_reg);
                cap_wdata = cap_rdata + eps_reg;
                nd_we     = 1'b1;
                nd_waddr  = j_idx;
                nd_wdata  = '{nxt: nj_reg.nxt, label: nj_reg.label,
                              excess: nj_reg.excess + EW'(eps_reg)};
                if (!sat_reg) begin
                    cur_ex_next = cur_ex_reg - EW'(eps_reg);
                    pushed_next = 1'b1;
                end
                if ((j_idx != s_reg) && (j_idx != t_reg) && (nj_reg.excess == '0)) begin
                    ba_b_next   = nj_reg.label;
                    ba_v_next   = j_idx;
                    ba_ret_next = 1'b1;
                    state_next  = ST_BA0;
                end else begin
                    state_next = ST_SC3;
                end
            end

            ST_SC3: begin
                if (!sat_reg && (cur_ex_reg == '0)) begin
                    state_next = ST_END;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_SC0;
                end
            end

            ST_END: begin
                state_next = ST_PK0;
                if (sat_reg) begin
                    sat_next = 1'b0;
                end else if (pushed_reg) begin
                    nd_we    = 1'b1;
                    nd_waddr = i_reg;
                    nd_wdata = '{nxt: cur_nxt_reg, label: cur_lbl_reg, excess: cur_ex_reg};
                    if (cur_ex_reg != '0) begin
                        ba_b_next   = cur_lbl_reg;
                        ba_v_next   = i_reg;
                        ba_ret_next = 1'b0;
                        state_next  = ST_BA0;
                    end
                end else if (least_ok_reg) begin
                    // Relabel to one above the lowest residual neighbor.
                    nd_we    = 1'b1;
                    nd_waddr = i_reg;
                    nd_wdata = '{nxt: cur_nxt_reg, label: new_lbl, excess: cur_ex_reg};
                    ba_b_next   = new_lbl;
                    ba_v_next   = i_reg;
                    ba_ret_next = 1'b0;
                    state_next  = ST_BA0;
                end
            end

            ST_BA0: begin
                if (ba_b_reg > highest_reg) highest_next = ba_b_reg;
                if (!nonempty_reg[ba_b_reg]) begin
                    nonempty_next[ba_b_reg] = 1'b1;
                    bk_we      = 1'b1;
                    bk_waddr   = ba_b_reg;
                    bk_wdata   = '{head: ba_v_reg, tail: ba_v_reg};
                    state_next = ba_ret_reg ? ST_SC3 : ST_PK0;
                end else begin
                    bk_raddr   = ba_b_reg;
                    state_next = ST_BA1;
                end
            end

            ST_BA1: begin
                bk_we        = 1'b1;
                bk_waddr     = ba_b_reg;
                bk_wdata     = '{head: bk_rdata.head, tail: ba_v_reg};
                nd_raddr     = bk_rdata.tail;
                ba_tail_next = bk_rdata.tail;
                state_next   = ST_BA2;
            end

            ST_BA2: begin
                // Link the new node behind the old tail.
                nd_we      = 1'b1;
                nd_waddr   = ba_tail_reg;
                nd_wdata   = '{nxt: ba_v_reg, label: nd_rdata.label, excess: nd_rdata.excess};
                state_next = ba_ret_reg ? ST_SC3 : ST_PK0;
            end

            ST_EM0: begin
                nd_raddr   = t_reg;
                state_next = ST_EM1;
            end

            ST_EM1: begin
                flow_next  = t_ok_reg ? flow_wide[FLOW_BITS-1:0] : '0;
                j_next     = '0;
                state_next = ST_EM2;
            end

            ST_EM2: begin
                if (j_reg == n_reg) begin
                    state_next = ST_IDLE;
                end else begin
                    nd_raddr   = j_idx;
                    state_next = ST_EM3;
                end
            end

            ST_EM3: begin
                nd_raddr        = j_idx;
                res_valid       = 1'b1;
                res.node_id     = k_wide[4:0];
                res.source_side = nd_rdata.label >= LW'(n_reg);
                res.max_flow    = flow_reg;
                res.last        = j_reg == (n_reg - 1'b1);
                if (res_ready) begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_EM2;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLR;
            ptr_reg      <= '0;
            nonempty_reg <= '0;
            highest_reg  <= '0;
            sat_reg      <= 1'b0;
            pushed_reg   <= 1'b0;
            least_ok_reg <= 1'b0;
            ba_ret_reg   <= 1'b0;
            ok_reg       <= 1'b0;
            t_ok_reg     <= 1'b0;
            j_reg        <= '0;
            n_reg        <= NCW'(2);
        end else begin
            state_reg    <= state_next;
            ptr_reg      <= ptr_next;
            nonempty_reg <= nonempty_next;
            highest_reg  <= highest_next;
            sat_reg      <= sat_next;
            pushed_reg   <= pushed_next;
            least_ok_reg <= least_ok_next;
            ba_ret_reg   <= ba_ret_next;
            ok_reg       <= ok_next;
            t_ok_reg     <= t_ok_next;
            j_reg        <= j_next;
            n_reg        <= n_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg         <= i_next;
        cur_ex_reg    <= cur_ex_next;
        cur_lbl_reg   <= cur_lbl_next;
        cur_nxt_reg   <= cur_nxt_next;
        least_reg     <= least_next;
        eps_reg       <= eps_next;
        nj_reg        <= nj_next;
        pick_b_reg    <= pick_b_next;
        pick_tail_reg <= pick_tail_next;
        pick_last_reg <= pick_last_next;
        ba_b_reg      <= ba_b_next;
        ba_v_reg      <= ba_v_next;
        ba_tail_reg   <= ba_tail_next;
        s_reg         <= s_next;
        t_reg         <= t_next;
        flow_reg      <= flow_next;
    end

endmodule
